>>> design/wsfhp_pkg.sv
// types and constants shared by the websocket frame header parser
package wsfhp_pkg;

  localparam logic [7:0]  RsvMask     = 8'h70;
  localparam logic [7:0]  OpMask      = 8'h0F;
  localparam logic [6:0]  Len16Code   = 7'd126;
  localparam logic [6:0]  Len64Code   = 7'd127;
  localparam logic [15:0] CtrlMaxLen  = 16'd125;
  localparam logic [3:0]  ShortHdrLen = 4'd2;
  localparam logic [3:0]  KeyBytes    = 4'd4;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_RSV       = 3'd1,
    ERR_OPCODE    = 3'd2,
    ERR_UNMASKED  = 3'd3,
    ERR_MASKED    = 3'd4,
    ERR_FRAG_CTRL = 3'd5,
    ERR_CTRL_LEN  = 3'd6,
    ERR_LEN       = 3'd7
  } err_e;

  typedef enum logic [1:0] {
    LEN_SHORT = 2'd0,
    LEN_16    = 2'd1,
    LEN_64    = 2'd2
  } len_form_e;

  typedef enum logic {
    ROLE_SERVER = 1'b0,
    ROLE_CLIENT = 1'b1
  } role_e;

  typedef struct packed {
    logic [3:0]  pos;
    logic [7:0]  first_byte;
    logic [63:0] len;
    len_form_e   form;
    logic        mask;
    logic [31:0] key;
    logic        err;
    err_e        code;
  } state_t;

  typedef struct packed {
    logic        status;
    logic        fin;
    logic [3:0]  opcode;
    logic [62:0] frame_len;
    logic        masked;
    logic [31:0] key_word;
    logic [3:0]  hdr_bytes;
    logic [2:0]  error_code;
  } parse_res_t;

endpackage

>>> design/wsfhp_step.sv
// per-byte next-state and result logic of the header parser
module wsfhp_step (
  input  wsfhp_pkg::state_t     state_i,
  input  logic [7:0]            byte_i,
  input  logic                  role_i,
  output wsfhp_pkg::state_t     state_o,
  output wsfhp_pkg::parse_res_t res_o,
  output logic                  res_valid_o
);
  import wsfhp_pkg::*;

  function automatic err_e check_second(logic [7:0] fb, logic [7:0] b, logic role);
    logic [3:0] op;
    err_e       code;
    op   = fb[3:0];
    code = ERR_NONE;
    if ((fb & RsvMask) != 8'h00) begin
      code = ERR_RSV;
    end else if (!(op <= 4'd2 || (op >= 4'd8 && op <= 4'd10))) begin
      code = ERR_OPCODE;
    end else if (role == ROLE_SERVER && !b[7]) begin
      code = ERR_UNMASKED;
    end else if (role == ROLE_CLIENT && b[7]) begin
      code = ERR_MASKED;
    end else if (op[3] && !fb[7]) begin
      code = ERR_FRAG_CTRL;
    end else if (op[3] && ({9'd0, b[6:0]} > CtrlMaxLen)) begin
      code = ERR_CTRL_LEN;
    end
    return code;
  endfunction

  function automatic parse_res_t frame(state_t s, logic [3:0] hlen);
    parse_res_t r;
    r            = '0;
    r.fin        = s.first_byte[7];
    r.opcode     = s.first_byte[3:0] & OpMask[3:0];
    r.frame_len  = s.len[62:0];
    r.masked     = s.mask;
    r.key_word   = s.mask ? s.key : 32'd0;
    r.hdr_bytes  = hlen;
    return r;
  endfunction

  function automatic state_t go_idle(state_t s);
    state_t r;
    r            = s;
    r.pos        = 4'd0;
    r.first_byte = 8'd0;
    r.len        = 64'd0;
    r.form       = LEN_SHORT;
    r.mask       = 1'b0;
    r.key        = 32'd0;
    return r;
  endfunction

  err_e        code;
  logic [3:0]  ext;
  logic [3:0]  end_pos;
  logic [1:0]  k;
  logic [63:0] len_nxt;

  always_comb begin
    state_o     = state_i;
    res_o       = '0;
    res_valid_o = 1'b0;
    code        = ERR_NONE;
    case (state_i.form)
      LEN_16:  ext = 4'd2;
      LEN_64:  ext = 4'd8;
      default: ext = 4'd0;
    endcase
    end_pos = ShortHdrLen + ext;
    k       = 2'(state_i.pos - end_pos);
    len_nxt = {state_i.len[55:0], byte_i};

    if (state_i.err) begin
      res_valid_o      = 1'b1;
      res_o.status     = 1'b1;
      res_o.error_code = state_i.code;
    end else if (state_i.pos == 4'd0) begin
      state_o.first_byte = byte_i;
      state_o.pos        = 4'd1;
    end else if (state_i.pos == 4'd1) begin
      code = check_second(state_i.first_byte, byte_i, role_i);
      if (code != ERR_NONE) begin
        res_valid_o      = 1'b1;
        res_o.status     = 1'b1;
        res_o.error_code = code;
        state_o.err      = 1'b1;
        state_o.code     = code;
      end else begin
        state_o.mask = byte_i[7];
        if (byte_i[6:0] == Len16Code) begin
          state_o.form = LEN_16;
        end else if (byte_i[6:0] == Len64Code) begin
          state_o.form = LEN_64;
        end else begin
          state_o.form = LEN_SHORT;
          state_o.len  = {57'd0, byte_i[6:0]};
        end
        state_o.pos = 4'd2;
        if (state_o.form == LEN_SHORT && !byte_i[7]) begin
          res_valid_o = 1'b1;
          res_o       = frame(state_o, ShortHdrLen);
          state_o     = go_idle(state_o);
        end
      end
    end else if (state_i.pos < end_pos) begin
      // extended length, big endian
      state_o.len = len_nxt;
      state_o.pos = state_i.pos + 4'd1;
      if (state_o.pos == end_pos) begin
        if ((state_i.form == LEN_16 && len_nxt[15:0] <= CtrlMaxLen) ||
            (state_i.form != LEN_16 && (len_nxt[63] || len_nxt[63:16] == 48'd0))) begin
          res_valid_o      = 1'b1;
          res_o.status     = 1'b1;
          res_o.error_code = ERR_LEN;
          state_o.err      = 1'b1;
          state_o.code     = ERR_LEN;
        end else if (!state_i.mask) begin
          res_valid_o = 1'b1;
          res_o       = frame(state_o, end_pos);
          state_o     = go_idle(state_o);
        end
      end
    end else begin
      // mask key, first byte lands in the low bits
      state_o.key[{k, 3'b000} +: 8] = byte_i;
      state_o.pos                   = state_i.pos + 4'd1;
      if (k == 2'd3) begin
        res_valid_o = 1'b1;
        res_o       = frame(state_o, end_pos + KeyBytes);
        state_o     = go_idle(state_o);
      end
    end
  end

endmodule

>>> design/websocket_frame_header_parser_unit.sv
// top level of the websocket frame header parser
// Takes one frame header byte per transfer and gives one result per header:
// a complete header (fin, opcode, payload length, mask, key, header length)
// or an error code, which is sticky and repeated for every later byte until
// reset. Set role (0 server, 1 client) through cfg_we_i/cfg_wdata_i while idle.
// A byte can be taken in every cycle unless a finished result is held up by a
// stalled output; each byte passes through an input register and one step of
// combinational decode into the result register. The input register keeps
// taking bytes that finish nothing while a result waits downstream.
module websocket_frame_header_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  header_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic        fin_o,
  output logic [3:0]  opcode_o,
  output logic [62:0] frame_len_o,
  output logic        masked_o,
  output logic [31:0] key_word_o,
  output logic [3:0]  hdr_bytes_o,
  output logic [2:0]  error_code_o
);
  import wsfhp_pkg::*;

  logic       role_q;
  logic       in_valid_q;
  logic       in_valid_d;
  logic [7:0] in_byte_q;
  state_t     state_q;
  state_t     state_d;
  parse_res_t res;
  logic       res_valid;
  parse_res_t out_q;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       advance;

  wsfhp_step u_step (
    .state_i     (state_q),
    .byte_i      (in_byte_q),
    .role_i      (role_q),
    .state_o     (state_d),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  // a held byte moves on unless its result would hit a stalled output
  assign advance    = in_valid_q && (!res_valid || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q      <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        role_q <= cfg_wdata_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= header_byte_i;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign fin_o         = out_q.fin;
  assign opcode_o      = out_q.opcode;
  assign frame_len_o   = out_q.frame_len;
  assign masked_o      = out_q.masked;
  assign key_word_o    = out_q.key_word;
  assign hdr_bytes_o   = out_q.hdr_bytes;
  assign error_code_o  = out_q.error_code;

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.err |=> state_q.err)
    else $error("latched error cleared");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid && !res.status) |=> (state_q.pos == 4'd0))
    else $error("parser not idle after complete header");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |->
      (error_code_o != ERR_NONE && hdr_bytes_o == 4'd0 && frame_len_o == 63'd0))
    else $error("error result carries frame fields");

  a_ok_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !status_o) |->
      (error_code_o == ERR_NONE && hdr_bytes_o >= ShortHdrLen))
    else $error("complete result malformed");

endmodule
